// ===== rtl/core/ctet_pkg.sv =====
`timescale 1ns / 1ps

package ctet_pkg;

	localparam int PREC_W    = 7;
	localparam int MAX_BYTES = 8;
	localparam int CNT_W     = 4;
	localparam int IDX_W     = 3;

	localparam logic [PREC_W-1:0] PREC_RESET = 7'd5;

	localparam logic MODE_COMMAND = 1'b1;

	// Number encoding constants of the charstring format.
	localparam int          SMALL_MAX    = 107;
	localparam int          TWO_MAX      = 1131;
	localparam logic [10:0] TWO_OFFSET   = 11'd108;
	localparam logic [7:0]  ONE_BIAS     = 8'd139;
	localparam logic [7:0]  TWO_POS_LEAD = 8'd247;
	localparam logic [7:0]  TWO_NEG_LEAD = 8'd251;
	localparam logic [7:0]  FIVE_LEAD    = 8'd255;
	localparam logic [7:0]  BYTE_ESCAPE  = 8'd12;
	localparam logic [7:0]  OP_DIV_LOW   = 8'd12;

	localparam logic [IDX_W-1:0] LEN_ONE  = 3'd1;
	localparam logic [IDX_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [IDX_W-1:0] LEN_FIVE = 3'd5;

	typedef logic [7:0] byte_t;

	// One fully encoded item: up to eight bytes and how many are in use.
	typedef struct packed {
		byte_t [MAX_BYTES-1:0] bytes;
		logic [CNT_W-1:0]      count;
	} token_t;

endpackage

// ===== rtl/core/charstring_token_encoder_top.sv =====
// Charstring token encoder. Each input beat carries either a signed Q16.16
// operand (mode 0) or an operator code (mode 1) and produces one to eight
// output beats of one byte each, the final byte of the item flagged by last.
// The front end takes one item per clock while its queue has room: two
// pipeline stages find the magnitude and then the precision-scaled value and
// fraction test, and the byte image of the item is packed into a queue of
// QUEUE_DEPTH entries. The back end emits one byte per clock from that
// queue into an output register while the queue holds an item and
// out_stall is low; most operands and operators are one or two bytes, and
// a fractional operand with a five-byte integer takes eight bytes. An
// input beat passes the stage 1 and stage 2 registers, a queue entry and
// the output register before its first output beat. The precision register
// (reset 5) is written over the cfg channel, which is always ready, and
// should only be written while no items are in flight.
`timescale 1ns / 1ps

module charstring_token_encoder_top #(
	parameter int ESCAPE_DELTA = 32,
	parameter int FRAC_BITS    = 16,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ctet_pkg::PREC_W-1:0] precision,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic signed [31:0]          operand_value,
	input  logic [5:0]                  command_code,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        last
);

	logic [ctet_pkg::PREC_W-1:0] prec_q;
	logic                        push_valid, push_ready, pop_valid, pop_ready;
	ctet_pkg::token_t            push_data, pop_data;

	// The precision register accepts a write on every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q <= ctet_pkg::PREC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			prec_q <= precision;
		end
	end

	// Front end: accepts items, scales operands and packs the byte image.
	ctet_front #(
		.ESCAPE_DELTA (ESCAPE_DELTA),
		.FRAC_BITS    (FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.operand_value (operand_value),
		.command_code  (command_code),
		.prec          (prec_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	// Queue of packed items between the two halves.
	ctet_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back end: serializes each packed item one byte per beat.
	ctet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ===== rtl/core/ctet_front.sv =====
`timescale 1ns / 1ps

module ctet_front #(
	parameter int ESCAPE_DELTA = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic signed [31:0]           operand_value,
	input  logic [5:0]                   command_code,
	input  logic [ctet_pkg::PREC_W-1:0]  prec,
	output logic                         push_valid,
	input  logic                         push_ready,
	output ctet_pkg::token_t             push_data
);

	localparam int FW  = (FRAC_BITS > 0) ? FRAC_BITS : 1;
	localparam int PW  = 32 + ctet_pkg::PREC_W;
	localparam int FPW = FW + ctet_pkg::PREC_W;

	logic        en1, en2;
	logic [31:0] raw, mag_in;

	logic        valid_s1, mode_s1, neg_s1;
	logic [5:0]  code_s1;
	logic [31:0] mag_s1;

	logic [PW-1:0]  prod, sc_mag, m_next;
	logic [31:0]    ip_mag;
	logic [FW-1:0]  frac_part;
	logic [FPW-1:0] fprod;
	logic           frac_next;

	logic          valid_s2, mode_s2, neg_s2, frac_s2;
	logic [5:0]    code_s2;
	logic [PW-1:0] m_s2;

	ctet_pkg::token_t          tok;
	logic [ctet_pkg::IDX_W-1:0] base;
	logic [10:0]               diff;
	logic [31:0]               word;

	assign en2      = !valid_s2 || push_ready;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	// Stage 1: sign and magnitude of the operand.
	assign raw    = operand_value;
	assign mag_in = raw[31] ? (~raw + 32'd1) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			mode_s1 <= mode;
			code_s1 <= command_code;
			neg_s1  <= raw[31];
			mag_s1  <= mag_in;
		end
	end

	// Stage 2: scale by the precision. A fraction remains exactly when the
	// fraction bits times the precision reach one whole unit.
	assign prod      = PW'(mag_s1) * PW'(prec);
	assign sc_mag    = prod >> FRAC_BITS;
	assign ip_mag    = mag_s1 >> FRAC_BITS;
	assign frac_part = (FRAC_BITS > 0) ? mag_s1[FW-1:0] : '0;
	assign fprod     = FPW'(frac_part) * FPW'(prec);
	assign frac_next = (fprod >> FRAC_BITS) != '0;
	assign m_next    = frac_next ? sc_mag : PW'(ip_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			mode_s2 <= mode_s1;
			code_s2 <= code_s1;
			neg_s2  <= neg_s1;
			frac_s2 <= frac_next;
			m_s2    <= m_next;
		end
	end

	// Byte packing of the stage 2 item.
	assign diff = m_s2[10:0] - ctet_pkg::TWO_OFFSET;
	assign word = neg_s2 ? (~m_s2[31:0] + 32'd1) : m_s2[31:0];

	always_comb begin
		tok  = '0;
		base = ctet_pkg::LEN_ONE;
		if (mode_s2 == ctet_pkg::MODE_COMMAND) begin
			if (code_s2 >= 6'(ESCAPE_DELTA)) begin
				tok.bytes[0] = ctet_pkg::BYTE_ESCAPE;
				tok.bytes[1] = {2'b00, code_s2 - 6'(ESCAPE_DELTA)};
				tok.count    = ctet_pkg::CNT_W'(ctet_pkg::LEN_TWO);
			end else begin
				tok.bytes[0] = {2'b00, code_s2};
				tok.count    = ctet_pkg::CNT_W'(ctet_pkg::LEN_ONE);
			end
		end else begin
			if (m_s2 <= PW'(ctet_pkg::SMALL_MAX)) begin
				tok.bytes[0] = neg_s2 ? (ctet_pkg::ONE_BIAS - m_s2[7:0])
				                      : (ctet_pkg::ONE_BIAS + m_s2[7:0]);
				base = ctet_pkg::LEN_ONE;
			end else if (m_s2 <= PW'(ctet_pkg::TWO_MAX)) begin
				tok.bytes[0] = (neg_s2 ? ctet_pkg::TWO_NEG_LEAD : ctet_pkg::TWO_POS_LEAD)
				             + {6'b000000, diff[9:8]};
				tok.bytes[1] = diff[7:0];
				base = ctet_pkg::LEN_TWO;
			end else begin
				tok.bytes[0] = ctet_pkg::FIVE_LEAD;
				tok.bytes[1] = word[31:24];
				tok.bytes[2] = word[23:16];
				tok.bytes[3] = word[15:8];
				tok.bytes[4] = word[7:0];
				base = ctet_pkg::LEN_FIVE;
			end
			tok.count = ctet_pkg::CNT_W'(base);
			if (frac_s2) begin
				// Push the precision, then escape and div.
				tok.bytes[base] = {1'b0, prec} + ctet_pkg::ONE_BIAS;
				tok.bytes[base + ctet_pkg::IDX_W'(1)] = ctet_pkg::BYTE_ESCAPE;
				tok.bytes[base + ctet_pkg::IDX_W'(2)] = ctet_pkg::OP_DIV_LOW;
				tok.count = ctet_pkg::CNT_W'(base) + ctet_pkg::CNT_W'(3);
			end
		end
	end

	assign push_valid = valid_s2;
	assign push_data  = tok;

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !push_ready |=> valid_s2 && $stable(m_s2) && $stable(mode_s2))
		else $error("stage 2 item changed while the queue was full");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en2 |=> valid_s1 && $stable(mag_s1))
		else $error("stage 1 item changed while stage 2 was blocked");

endmodule

// ===== rtl/core/ctet_queue.sv =====
`timescale 1ns / 1ps

module ctet_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  ctet_pkg::token_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output ctet_pkg::token_t pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ctet_pkg::token_t entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + CW'(1))
		else $error("queue fill count missed a push");

endmodule

// ===== rtl/core/ctet_back.sv =====
`timescale 1ns / 1ps

module ctet_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  ctet_pkg::token_t pop_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	logic [ctet_pkg::IDX_W-1:0] idx_q;
	logic                       out_valid_q, last_q;
	logic [7:0]                 out_byte_q;
	logic                       load, is_last;

	assign load      = pop_valid && (!out_valid_q || !out_stall);
	assign is_last   = (ctet_pkg::CNT_W'(idx_q) + ctet_pkg::CNT_W'(1)) == pop_data.count;
	assign pop_ready = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + ctet_pkg::IDX_W'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= pop_data.bytes[idx_q];
			last_q     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	a_idx_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> ctet_pkg::CNT_W'(idx_q) < pop_data.count)
		else $error("byte index past the end of the queued item");

	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> pop_data.count != '0 &&
		              pop_data.count <= ctet_pkg::CNT_W'(ctet_pkg::MAX_BYTES))
		else $error("queued item has an impossible byte count");

endmodule
